@@ src/afat_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the animation frame lookup block.
// No dependencies; used by afat_rem and animation_frame_at_tick.
package afat_pkg;

   localparam int MAX_FRAMES_DEF = 256;

   localparam int CMD_W   = 1;
   localparam int SLOT_W  = 8;
   localparam int DUR_W   = 16;
   localparam int MAP_W   = 16;
   localparam int TICK_W  = 31;
   localparam int FRAME_W = 8;
   localparam int COUNT_W = 9;
   // 256 frames of at most 65535 ticks each stay below 2**24
   localparam int SUM_W   = 24;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
   localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_TOTAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_FIRST  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_ENABLE = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [SLOT_W-1:0] entry_slot;
      logic [DUR_W-1:0]  entry_duration;
      logic [MAP_W-1:0]  entry_map;
      logic [TICK_W-1:0] query_tick;
   } req_type;

   typedef struct packed {
      logic [FRAME_W-1:0] shown_frame;
      logic [MAP_W-1:0]   shown_map;
   } rsp_type;

   typedef struct packed {
      logic              start;
      logic [TICK_W-1:0] dividend;
      logic [SUM_W-1:0]  divisor;
   } rem_req_type;

endpackage

@@ src/afat_rem.sv @@
`timescale 1ns / 1ps
// Bit-serial restoring remainder unit: one quotient bit per cycle.
// Depends on afat_pkg for widths and the request struct.
module afat_rem (
   input  logic                        clock,
   input  logic                        reset,
   input  afat_pkg::rem_req_type       rem_req,
   output logic                        rem_done,
   output logic [afat_pkg::SUM_W-1:0]  rem_value
);

   localparam int CNT_W = $clog2(afat_pkg::TICK_W);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [afat_pkg::TICK_W-1:0]   dvd_ff, dvd_in;
   logic [afat_pkg::SUM_W-1:0]    dsr_ff, dsr_in;
   logic [afat_pkg::SUM_W-1:0]    rem_ff, rem_in;
   logic [afat_pkg::SUM_W:0]      rem_sh;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      rem_sh  = {rem_ff, dvd_ff[afat_pkg::TICK_W-1]};
      if (rem_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = rem_req.dividend;
         dsr_in  = rem_req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         if (rem_sh >= {1'b0, dsr_ff}) begin
            rem_in = afat_pkg::SUM_W'(rem_sh - {1'b0, dsr_ff});
         end else begin
            rem_in = rem_sh[afat_pkg::SUM_W-1:0];
         end
         dvd_in = {dvd_ff[afat_pkg::TICK_W-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(afat_pkg::TICK_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         dvd_ff  <= dvd_in;
         dsr_ff  <= dsr_in;
         rem_ff  <= rem_in;
      end
   end

   assign rem_done  = done_ff;
   assign rem_value = rem_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < dsr_ff))
      else $error("remainder not below divisor");

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("done while still busy");

   a_step_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff < CNT_W'(afat_pkg::TICK_W)))
      else $error("step count past dividend width");

endmodule

@@ src/animation_frame_at_tick.sv @@
`timescale 1ns / 1ps
// Top level of the sprite animation frame lookup: frame table, sequencer,
// result register. Depends on afat_pkg and afat_rem.
//
//  channel  | ports                                  | transfer moves
//  ---------+----------------------------------------+-------------------------
//  req      | req_valid, req_ready, req_data         | one load or query item
//  rsp      | rsp_valid, rsp_ready, rsp_data         | frame and map of a query
//  csr      | csr_valid, csr_ready, csr_index/data   | one register write
//
// A load writes one table entry. A query sums the duration table, decides,
// runs the bit-serial remainder unit only when a looped tick lies past the end,
// walks the table again and reads the map entry. Both walks go through the
// single table read port that they share.
// Reset is synchronous; registers return to frame_total 1, no loop.
// The result register frees req_ready while a result waits on rsp_ready.
module animation_frame_at_tick #(
   parameter int MAX_FRAMES = afat_pkg::MAX_FRAMES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  afat_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output afat_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [afat_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [afat_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int AW          = $clog2(MAX_FRAMES);
   localparam int FRAME_LIMIT = (MAX_FRAMES < 256) ? MAX_FRAMES : 256;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_DECIDE,
      ST_DIV,
      ST_PICK,
      ST_MAP,
      ST_FIN
   } state_type;

   // frame table
   logic [afat_pkg::DUR_W-1:0] dur_mem [MAX_FRAMES];
   logic [afat_pkg::MAP_W-1:0] map_mem [MAX_FRAMES];
   logic [afat_pkg::DUR_W-1:0] rd_dur_ff;
   logic [afat_pkg::MAP_W-1:0] rd_map_ff;
   logic [AW-1:0]              rd_addr;
   logic [AW-1:0]              wr_addr;
   logic                       load_we;

   // configuration
   logic [afat_pkg::COUNT_W-1:0] frame_total_ff, frame_total_in;
   logic [afat_pkg::FRAME_W-1:0] loop_first_ff, loop_first_in;
   logic                         loop_enable_ff, loop_enable_in;

   // sequencer
   state_type                    state_ff, state_in;
   logic [afat_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [afat_pkg::FRAME_W-1:0] first_ff, first_in;
   logic                         loop_ff, loop_in;
   logic [afat_pkg::TICK_W-1:0]  qtick_ff, qtick_in;
   logic [afat_pkg::COUNT_W-1:0] iss_ff, iss_in;
   logic                         rvld_ff, rvld_in;
   logic [afat_pkg::FRAME_W-1:0] ridx_ff, ridx_in;
   logic [afat_pkg::SUM_W-1:0]   total_ff, total_in;
   logic [afat_pkg::SUM_W-1:0]   lead_ff, lead_in;
   logic [afat_pkg::SUM_W-1:0]   add_ff, add_in;
   logic [afat_pkg::SUM_W-1:0]   wtick_ff, wtick_in;
   logic [afat_pkg::FRAME_W-1:0] last_ff, last_in;
   logic [afat_pkg::FRAME_W-1:0] frame_ff, frame_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   afat_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic [afat_pkg::COUNT_W-1:0] q_count;
   logic [afat_pkg::FRAME_W-1:0] q_first;
   logic [afat_pkg::SUM_W-1:0]   span;
   logic                         issue_ok;

   afat_pkg::rem_req_type        rem_req;
   logic                         rem_done;
   logic [afat_pkg::SUM_W-1:0]   rem_value;

   afat_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .rem_req   (rem_req),
      .rem_done  (rem_done),
      .rem_value (rem_value)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Loads write the table directly; queries never overlap them.
   assign load_we = req_valid && req_ready && (req_data.cmd == afat_pkg::CMD_LOAD) &&
                    (32'(req_data.entry_slot) < 32'(MAX_FRAMES));
   assign wr_addr = AW'(req_data.entry_slot);

   // Walk address during the two passes, otherwise the chosen frame.
   assign rd_addr = ((state_ff == ST_SUM) || (state_ff == ST_PICK)) ?
                    AW'(iss_ff) : AW'(frame_ff);

   always_ff @(posedge clock) begin
      if (load_we) begin
         dur_mem[wr_addr] <= req_data.entry_duration;
         map_mem[wr_addr] <= req_data.entry_map;
      end
      rd_dur_ff <= dur_mem[rd_addr];
      rd_map_ff <= map_mem[rd_addr];
   end

   // Clamp the frame count and the loop start at query time.
   always_comb begin
      if (frame_total_ff == '0) begin
         q_count = afat_pkg::COUNT_W'(1);
      end else if (32'(frame_total_ff) > 32'(FRAME_LIMIT)) begin
         q_count = afat_pkg::COUNT_W'(FRAME_LIMIT);
      end else begin
         q_count = frame_total_ff;
      end
      if ({1'b0, loop_first_ff} >= q_count) begin
         q_first = '0;
      end else begin
         q_first = loop_first_ff;
      end
   end

   assign span     = total_ff - lead_ff;
   assign issue_ok = (iss_ff < count_ff);

   always_comb begin
      frame_total_in = frame_total_ff;
      loop_first_in  = loop_first_ff;
      loop_enable_in = loop_enable_ff;
      state_in       = state_ff;
      count_in       = count_ff;
      first_in       = first_ff;
      loop_in        = loop_ff;
      qtick_in       = qtick_ff;
      iss_in         = iss_ff;
      rvld_in        = 1'b0;
      ridx_in        = ridx_ff;
      total_in       = total_ff;
      lead_in        = lead_ff;
      add_in         = add_ff;
      wtick_in       = wtick_ff;
      last_in        = last_ff;
      frame_in       = frame_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rem_req        = '0;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            afat_pkg::CSR_FRAME_TOTAL: frame_total_in = csr_data;
            afat_pkg::CSR_LOOP_FIRST:  loop_first_in  = csr_data[afat_pkg::FRAME_W-1:0];
            afat_pkg::CSR_LOOP_ENABLE: loop_enable_in = csr_data[0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_data.cmd == afat_pkg::CMD_QUERY)) begin
               count_in = q_count;
               first_in = q_first;
               loop_in  = loop_enable_ff;
               qtick_in = req_data.query_tick;
               iss_in   = '0;
               total_in = '0;
               lead_in  = '0;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            // accumulate; the running sum at the loop start is the lead-in
            if (rvld_ff) begin
               total_in = total_ff + afat_pkg::SUM_W'(rd_dur_ff);
               if (ridx_ff == first_ff) begin
                  lead_in = total_ff;
               end
            end
            if (issue_ok) begin
               iss_in  = iss_ff + afat_pkg::COUNT_W'(1);
               rvld_in = 1'b1;
               ridx_in = iss_ff[afat_pkg::FRAME_W-1:0];
            end else if (!rvld_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            iss_in  = '0;
            last_in = '0;
            if (total_ff == '0) begin
               frame_in = '0;
               state_in = ST_MAP;
            end else if (qtick_ff < afat_pkg::TICK_W'(total_ff)) begin
               wtick_in = qtick_ff[afat_pkg::SUM_W-1:0];
               state_in = ST_PICK;
            end else if (!loop_ff) begin
               // hold the last tick
               wtick_in = total_ff - afat_pkg::SUM_W'(1);
               state_in = ST_PICK;
            end else begin
               rem_req.start = 1'b1;
               if (span != '0) begin
                  rem_req.dividend = qtick_ff - afat_pkg::TICK_W'(lead_ff);
                  rem_req.divisor  = span;
                  add_in           = lead_ff;
               end else begin
                  rem_req.dividend = qtick_ff;
                  rem_req.divisor  = total_ff;
                  add_in           = '0;
               end
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (rem_done) begin
               wtick_in = add_ff + rem_value;
               iss_in   = '0;
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            // skip empty frames, stop at the first that covers the tick
            if (issue_ok) begin
               iss_in  = iss_ff + afat_pkg::COUNT_W'(1);
               rvld_in = 1'b1;
               ridx_in = iss_ff[afat_pkg::FRAME_W-1:0];
            end
            if (rvld_ff) begin
               last_in = ridx_ff;
               if (rd_dur_ff != '0) begin
                  if (wtick_ff < afat_pkg::SUM_W'(rd_dur_ff)) begin
                     frame_in = ridx_ff;
                     state_in = ST_MAP;
                  end else begin
                     wtick_in = wtick_ff - afat_pkg::SUM_W'(rd_dur_ff);
                  end
               end
            end else if (!issue_ok) begin
               frame_in = last_ff;
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // drop the result into the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.shown_frame = frame_ff;
               rsp_data_in.shown_map   = rd_map_ff;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_total_ff <= afat_pkg::COUNT_W'(1);
         loop_first_ff  <= '0;
         loop_enable_ff <= 1'b0;
         state_ff       <= ST_IDLE;
         iss_ff         <= '0;
         rvld_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         frame_total_ff <= frame_total_in;
         loop_first_ff  <= loop_first_in;
         loop_enable_ff <= loop_enable_in;
         state_ff       <= state_in;
         iss_ff         <= iss_in;
         rvld_ff        <= rvld_in;
         rsp_valid_ff   <= rsp_valid_in;
         count_ff       <= count_in;
         first_ff       <= first_in;
         loop_ff        <= loop_in;
         qtick_ff       <= qtick_in;
         ridx_ff        <= ridx_in;
         total_ff       <= total_in;
         lead_ff        <= lead_in;
         add_ff         <= add_in;
         wtick_ff       <= wtick_in;
         last_ff        <= last_in;
         frame_ff       <= frame_in;
         rsp_data_ff    <= rsp_data_in;
      end
   end

   a_lead_within_total: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) |-> (lead_ff <= total_ff))
      else $error("lead-in sum exceeds total");

   a_pick_tick_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PICK) |-> (wtick_ff < total_ff))
      else $error("working tick outside animation");

   a_frame_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) |-> ({1'b0, frame_ff} < count_ff))
      else $error("chosen frame not below frame count");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SUM) || (state_ff == ST_PICK)) |-> (iss_ff <= count_ff))
      else $error("table walk past frame count");

endmodule

@@ sim/animation_frame_at_tick_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the sprite animation frame lookup block: loads and
// tick queries are driven with random bursts and checked against a local predictor.
// Depends on afat_pkg and animation_frame_at_tick.
module animation_frame_at_tick_test;
   import afat_pkg::*;

   localparam int          FRAME_LIMIT = (MAX_FRAMES_DEF < 256) ? MAX_FRAMES_DEF : 256;
   localparam logic [30:0] TICK_MAX    = 31'h7FFF_FFFF;
   // spare idle clocks after draining, before a register write
   localparam int          IDLE_CYCLES = 8;
   localparam int          PHASES      = 16;
   localparam int          PHASE_ITEMS = 25;

   logic clock;
   logic reset;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   animation_frame_at_tick i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Predictor state: the frame table and registers as the block should see
   // them, updated only when a transfer or a register write actually happens.
   logic [DUR_W-1:0]   dur_copy [MAX_FRAMES_DEF];
   logic [MAP_W-1:0]   map_copy [MAX_FRAMES_DEF];
   logic [COUNT_W-1:0] total_reg = 9'd1;
   logic [7:0]         first_reg = 8'd0;
   logic               loop_reg  = 1'b0;
   rsp_type            frame_expected [$];

   // Stimulus side: items waiting for the driver, plus the durations as they
   // will be once every queued load has gone through (used to aim ticks).
   req_type            pending_items [$];
   logic [DUR_W-1:0]   plan_dur [MAX_FRAMES_DEF];

   int sent_total   = 0;
   int taken_total  = 0;
   int loads_seen   = 0;
   int queries_seen = 0;
   int results_seen = 0;
   int csr_writes   = 0;
   int settings     = 0;
   int errors       = 0;

   int gap_left     = 0;
   int burst_left   = 1;
   bit steady_sender = 1'b0;
   logic [7:0] stall_pat = 8'hFF;
   int stall_age     = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < MAX_FRAMES_DEF; i++) begin
         dur_copy[i] = '0;
         map_copy[i] = '0;
         plan_dur[i] = '0;
      end
   end

   // Frame count after clamping: zero acts as one, large values saturate.
   function automatic int unsigned eff_count();
      if (total_reg == 0) return 1;
      if (total_reg > FRAME_LIMIT) return FRAME_LIMIT;
      return total_reg;
   endfunction

   // A loop start at or past the frame count falls back to frame 0.
   function automatic int unsigned eff_first(input int unsigned cnt);
      return (first_reg < cnt) ? first_reg : 0;
   endfunction

   // Frame shown at a tick, and its map index, under the current registers.
   function automatic rsp_type lookup_frame(input logic [TICK_W-1:0] tick_in);
      int unsigned cnt, first, total, lead, span, tick, last, i;
      bit          found;
      rsp_type     shown;
      cnt   = eff_count();
      first = eff_first(cnt);
      tick  = tick_in;
      total = 0;
      lead  = 0;
      for (i = 0; i < cnt; i++) begin
         total += dur_copy[i];
         if (i < first) lead += dur_copy[i];
      end
      span = total - lead;
      last = 0;
      if (total != 0) begin
         if (!loop_reg) begin
            // one-shot: hold the last tick
            if (tick >= total) tick = total - 1;
         end else if (tick >= total) begin
            // loop: wrap into the looped span, or the whole run if it is empty
            if (span != 0) tick = lead + (tick - lead) % span;
            else tick = tick % total;
         end
         found = 1'b0;
         for (i = 0; i < cnt && !found; i++) begin
            last = i;
            // zero-length frames are stepped over, never shown
            if (dur_copy[i] != 0) begin
               if (tick < dur_copy[i]) found = 1'b1;
               else tick -= dur_copy[i];
            end
         end
      end
      shown.shown_frame = last[FRAME_W-1:0];
      shown.shown_map   = map_copy[last];
      return shown;
   endfunction

   // Apply one accepted transfer to the predictor.
   function automatic void apply_transfer(input req_type item);
      if (item.cmd == CMD_LOAD) begin
         if (int'(item.entry_slot) < MAX_FRAMES_DEF) begin
            dur_copy[item.entry_slot] = item.entry_duration;
            map_copy[item.entry_slot] = item.entry_map;
         end
         loads_seen++;
      end else begin
         frame_expected.push_back(lookup_frame(item.query_tick));
         queries_seen++;
      end
      taken_total++;
   endfunction

   // Compare one returned result with the oldest expectation.
   function automatic void check_result(input rsp_type got);
      rsp_type want;
      results_seen++;
      if (frame_expected.size() == 0) begin
         $error("unexpected result: shown_frame %0d shown_map 0x%04h",
                got.shown_frame, got.shown_map);
         errors++;
      end else begin
         want = frame_expected.pop_front();
         if (got.shown_frame !== want.shown_frame) begin
            $error("shown_frame: expected %0d, got %0d", want.shown_frame, got.shown_frame);
            errors++;
         end
         if (got.shown_map !== want.shown_map) begin
            $error("shown_map: expected 0x%04h, got 0x%04h", want.shown_map, got.shown_map);
            errors++;
         end
      end
   endfunction

   // Queue a load; fields the block ignores carry random bits.
   function automatic void gen_load(input int slot, input int dur, input int map);
      req_type item;
      item.cmd            = CMD_LOAD;
      item.entry_slot     = slot[SLOT_W-1:0];
      item.entry_duration = dur[DUR_W-1:0];
      item.entry_map      = map[MAP_W-1:0];
      item.query_tick     = TICK_W'($urandom);
      plan_dur[item.entry_slot] = item.entry_duration;
      pending_items.push_back(item);
      sent_total++;
   endfunction

   function automatic void gen_query(input logic [31:0] tick);
      req_type item;
      item.cmd            = CMD_QUERY;
      item.entry_slot     = SLOT_W'($urandom);
      item.entry_duration = DUR_W'($urandom);
      item.entry_map      = MAP_W'($urandom);
      item.query_tick     = tick[TICK_W-1:0];
      pending_items.push_back(item);
      sent_total++;
   endfunction

   // Aim a tick at the interesting spots of the table as it will stand.
   function automatic logic [31:0] pick_tick();
      int unsigned cnt, first, total, lead, i;
      logic [31:0] t;
      cnt   = eff_count();
      first = eff_first(cnt);
      total = 0;
      lead  = 0;
      for (i = 0; i < cnt; i++) begin
         total += plan_dur[i];
         if (i < first) lead += plan_dur[i];
      end
      case ($urandom_range(0, 9))
         0: t = 0;
         1: t = total - 1;
         2: t = total;
         3: t = total + 1;
         4: t = lead + (total - lead) * $urandom_range(1, 3);
         5: t = $urandom;
         6: t = {1'b0, TICK_MAX};
         default: t = $urandom_range(total * 3 + 1, 0);
      endcase
      return t & 32'h7FFF_FFFF;
   endfunction

   // Hold until every queued item is taken and every result is back.
   task automatic wait_drained();
      while (taken_total != sent_total || frame_expected.size() != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_FRAME_TOTAL: total_reg = value;
         CSR_LOOP_FIRST:  first_reg = value[7:0];
         CSR_LOOP_ENABLE: loop_reg  = value[0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      csr_writes++;
   endtask

   // Settle the block, then write all three registers.
   task automatic apply_setting(input logic [CSR_DATA_W-1:0] total_val,
                                input logic [CSR_DATA_W-1:0] first_val,
                                input logic [CSR_DATA_W-1:0] loop_val);
      wait_drained();
      write_csr(CSR_FRAME_TOTAL, total_val);
      write_csr(CSR_LOOP_FIRST, first_val);
      write_csr(CSR_LOOP_ENABLE, loop_val);
      settings++;
   endtask

   // Request driver: bursts of transfers separated by random gaps. A presented
   // item stays put until the block takes it.
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         gap_left   <= 0;
         burst_left <= 1;
      end else begin
         if (req_valid && req_ready) begin
            apply_transfer(req_data);
         end
         if (!(req_valid && !req_ready)) begin
            if (gap_left != 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               req_data  <= pending_items.pop_front();
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 24);
                  if (steady_sender) begin
                     gap_left <= 0;
                  end else if ($urandom_range(0, 3) == 0) begin
                     gap_left <= $urandom_range(10, 40);
                  end else begin
                     gap_left <= $urandom_range(0, 5);
                  end
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and receiver: ready follows a rotating stall pattern that is
   // reloaded whenever stall_age wraps, sometimes with no stalls at all.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_pat <= 8'hFF;
         stall_age <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_result(rsp_data);
         end
         if (stall_age == 31) begin
            stall_age <= 0;
            stall_pat <= ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
         end else begin
            stall_age <= stall_age + 1;
            stall_pat <= {stall_pat[0], stall_pat[7:1]};
         end
         rsp_ready <= stall_pat[0];
      end
   end

   initial begin
      int unsigned cnt, first;
      int          ph, k, s, style, dur;
      logic [CSR_DATA_W-1:0] total_val, first_val, loop_val;

      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Fill every slot first so no query can touch an entry never written.
      for (s = 0; s < MAX_FRAMES_DEF; s++) begin
         gen_load(s, $urandom_range(1, 9), $urandom);
      end

      // Reset values: a single frame, one-shot, ticks at both ends.
      gen_load(0, 3, 16'hFFFF);
      gen_query(0);
      gen_query({1'b0, TICK_MAX});

      // Four frames looping from frame 2, with a zero-length frame 1 to skip.
      apply_setting(9'd4, 9'd2, 9'd1);
      gen_load(1, 0, 16'h0001);
      gen_load(2, 16'hFFFF, 16'h0000);
      gen_load(3, 1, 16'h1234);
      gen_query(3);
      gen_query(65538);
      gen_query(65539);
      gen_query({1'b0, TICK_MAX});

      // Empty looped span: wrap over the whole animation instead.
      gen_load(2, 0, 16'h5A5A);
      gen_load(3, 0, 16'hC3C3);
      gen_query(7);
      gen_query({1'b0, TICK_MAX});

      // Every frame empty: frame 0 comes back.
      gen_load(0, 0, 16'hA5A5);
      gen_query(0);
      gen_query(100);

      // Loop start past the frame count falls back to frame 0.
      apply_setting(9'd4, 9'd255, 9'd1);
      gen_load(0, 2, 16'h0F0F);
      gen_load(2, 1, 16'hF0F0);
      gen_query(5);

      // Frame count zero, then counts that saturate at the table size.
      apply_setting(9'd0, 9'd0, 9'd0);
      gen_query(1000);
      apply_setting(9'h1FF, 9'h1FF, 9'h1FF);
      gen_load(255, 16'hFFFF, 16'hFFFF);
      gen_query({1'b0, TICK_MAX});
      apply_setting(9'd256, 9'd128, 9'd0);
      gen_query({1'b0, TICK_MAX});

      // Random phases: mostly small animations, a few full-size ones.
      for (ph = 0; ph < PHASES; ph++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: total_val = 9'($urandom_range(1, 8));
            6, 7:             total_val = 9'($urandom_range(9, 64));
            8:                total_val = 9'd256;
            default:          total_val = ($urandom_range(0, 1) == 0) ? 9'd0
                                                : 9'($urandom_range(257, 511));
         endcase
         cnt = (total_val == 0) ? 1 : ((total_val > FRAME_LIMIT) ? FRAME_LIMIT : total_val);
         case ($urandom_range(0, 3))
            0:       first_val = 9'd0;
            1:       first_val = {1'($urandom), 8'($urandom_range(0, cnt - 1))};
            2:       first_val = 9'($urandom);
            default: first_val = {1'($urandom), 8'(cnt - 1)};
         endcase
         loop_val = 9'($urandom);
         apply_setting(total_val, first_val, loop_val);
         first = eff_first(cnt);
         steady_sender = (ph % 5 == 2);

         // Reshape the table so the empty cases come up with real content.
         style = $urandom_range(0, 5);
         case (style)
            0: for (s = 0; s < cnt; s++) gen_load(s, 0, $urandom);
            1: for (s = first; s < cnt; s++) gen_load(s, 0, $urandom);
            2: for (s = 0; s < cnt; s++) gen_load(s, $urandom_range(0, 3), $urandom);
            default: ;
         endcase

         for (k = 0; k < PHASE_ITEMS; k++) begin
            // in some phases stop halfway until every result is back
            if (ph % 4 == 1 && k == PHASE_ITEMS / 2) wait_drained();
            if ($urandom_range(0, 3) == 0) begin
               case ($urandom_range(0, 7))
                  0, 1:    dur = 0;
                  2, 3:    dur = $urandom_range(1, 4);
                  4:       dur = 16'hFFFF;
                  default: dur = $urandom_range(0, 16'hFFFF);
               endcase
               s = ($urandom_range(0, 4) != 0) ? $urandom_range(0, cnt - 1)
                                               : $urandom_range(0, 255);
               gen_load(s, dur, $urandom);
            end else begin
               gen_query(pick_tick());
            end
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);

      $display("Run covered %0d loads and %0d queries (%0d results checked) over %0d",
               loads_seen, queries_seen, results_seen, settings);
      $display("register settings with %0d register writes.", csr_writes);
      if (errors == 0 && frame_expected.size() == 0) begin
         $display("** animation_frame_at_tick: PASSED **");
      end else begin
         $display("** animation_frame_at_tick: FAILED **");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #50_000_000;
      $display("** animation_frame_at_tick: FAILED **");
      $finish;
   end

endmodule
